// ----- design/bbspmv_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbspmv_pkg: shared types and constants of the bitmap blocked SpMV block
// Opcodes, field widths, accumulator limits and the lowest-set-bit encoder.
// ----------------------------------------------------------------------------
package bbspmv_pkg;

    localparam int BLOCK_EDGE = 8;
    localparam int EDGE_LOG2  = 3;
    localparam int OP_W       = 2;
    localparam int X_INDEX_W  = 12;
    localparam int DATA_W     = 16;
    localparam int BITMAP_W   = 64;
    localparam int BIT_IDX_W  = 6;
    localparam int COLUMN_W   = 9;
    localparam int PROD_W     = 32;
    localparam int SUM_W      = 48;
    localparam int ROW_W      = 3;

    // Number of x positions that a block column and a local column can name
    localparam int X_SPAN     = 4096;

    localparam logic signed [SUM_W-1:0] ACC_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] ACC_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    // Input word kinds
    typedef enum logic [OP_W-1:0] {
        OP_LOAD_X  = 2'd0,
        OP_HEADER  = 2'd1,
        OP_VALUE   = 2'd2,
        OP_ROW_END = 2'd3
    } op_t;

    // Word between the issue stage and the multiply stage
    typedef struct packed {
        logic                     eor;
        logic [ROW_W-1:0]         row;
        logic signed [DATA_W-1:0] data;
        logic                     x_ok;
        logic                     fault;
    } mac_stage_t;

    // Position of the lowest set bit (0 for an all-zero word)
    function automatic logic [BIT_IDX_W-1:0] lowest_set(input logic [BITMAP_W-1:0] v);
        logic [BITMAP_W-1:0]  iso;
        logic [BIT_IDX_W-1:0] k;
        iso = v & (~v + {{(BITMAP_W-1){1'b0}}, 1'b1});
        k   = '0;
        for (int i = 0; i < BITMAP_W; i++) begin
            if (iso[i]) begin
                k = k | BIT_IDX_W'(i);
            end
        end
        return k;
    endfunction

endpackage

// ----- design/bitmap_block_spmv.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_block_spmv: sparse matrix-vector multiply over 8x8 bitmap blocks
// Loads x, tracks the pending bitmap of the current block, multiplies each
// nonzero by its x element and accumulates into eight row sums, which are
// streamed out as eight words on every end-of-row word.
// ----------------------------------------------------------------------------
//
//  Channel | Dir | tdata (low bit up)                         | tuser  | tlast
//  --------+-----+-------------------------------------------+--------+------------
//  s_      | in  | x_index, data_value, nz_map, column        | opcode | -
//  m_      | out | row_sum, local_row                        | fault  | last_of_row
//
//  One input word per cycle while s_tready is high; a row end yields eight output
//  words, one per cycle while m_tready is high; the next row end waits for the last.
//  Row end path: input, issue and multiply registers, then the output buffer.
//  s_tready drops only while a row end waits in the last stage for the
//  output buffer to drain; the whole pipeline then holds.
//  Synchronous reset clears bitmap, column, fault, sums and valids, not x.
// ----------------------------------------------------------------------------
module bitmap_block_spmv #(
    parameter int NUM_BLOCK_COLUMNS = 512
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [103:0] s_tdata,   // x_index[11:0], data_value[27:12],
                                    // nz_map[91:28], block_column[100:92]
    input  logic [1:0]   s_tuser,   // opcode[1:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [55:0]  m_tdata,   // row_sum[47:0], local_row[50:48]
    output logic         m_tlast,   // last_of_row
    output logic [0:0]   m_tuser    // fault[0]
);

    localparam int X_DEPTH   = NUM_BLOCK_COLUMNS * bbspmv_pkg::BLOCK_EDGE;
    localparam int MEM_DEPTH = (X_DEPTH < bbspmv_pkg::X_SPAN) ? X_DEPTH : bbspmv_pkg::X_SPAN;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int CMP_W     = bbspmv_pkg::X_INDEX_W + 1;

    // ---------------- control and state registers ----------------
    logic                                  s1_valid_reg;
    bbspmv_pkg::op_t                       s1_op_reg;
    logic [bbspmv_pkg::X_INDEX_W-1:0]      s1_index_reg;
    logic signed [bbspmv_pkg::DATA_W-1:0]  s1_data_reg;
    logic [bbspmv_pkg::BITMAP_W-1:0]       s1_bitmap_reg;
    logic [bbspmv_pkg::COLUMN_W-1:0]       s1_column_reg;

    logic [bbspmv_pkg::BITMAP_W-1:0]       pending_reg;
    logic [bbspmv_pkg::COLUMN_W-1:0]       column_reg;
    logic                                  fault_reg;

    logic                                  s2_valid_reg;
    bbspmv_pkg::mac_stage_t                s2_reg;
    logic signed [bbspmv_pkg::DATA_W-1:0]  x_rd_reg;

    logic                                  s3_valid_reg;
    logic                                  s3_eor_reg;
    logic [bbspmv_pkg::ROW_W-1:0]          s3_row_reg;
    logic signed [bbspmv_pkg::PROD_W-1:0]  s3_prod_reg;
    logic                                  s3_fault_reg;

    logic signed [bbspmv_pkg::SUM_W-1:0]   acc_reg [bbspmv_pkg::BLOCK_EDGE];

    logic signed [bbspmv_pkg::SUM_W-1:0]   out_sum_reg [bbspmv_pkg::BLOCK_EDGE];
    logic                                  out_fault_reg;
    logic [bbspmv_pkg::ROW_W-1:0]          out_cnt_reg;
    logic                                  out_busy_reg;

    logic signed [bbspmv_pkg::DATA_W-1:0]  x_mem [MEM_DEPTH];

    // ---------------- combinational signals ----------------
    logic                                  advance;
    logic                                  buf_free;
    logic                                  out_take;
    logic                                  out_load;
    logic [bbspmv_pkg::BIT_IDX_W-1:0]      lo_bit;
    logic [bbspmv_pkg::X_INDEX_W-1:0]      x_pos;
    logic                                  x_ok;
    logic                                  wr_ok;
    logic                                  have_bits;
    logic [bbspmv_pkg::BITMAP_W-1:0]       pending_next;
    logic [bbspmv_pkg::COLUMN_W-1:0]       column_next;
    logic                                  fault_next;
    logic                                  s2_valid_next;
    bbspmv_pkg::mac_stage_t                s2_next;
    logic                                  mem_wr;
    logic signed [bbspmv_pkg::DATA_W-1:0]  x_operand;
    logic signed [bbspmv_pkg::PROD_W-1:0]  prod_next;
    logic signed [bbspmv_pkg::SUM_W:0]     sum_wide;
    logic signed [bbspmv_pkg::SUM_W-1:0]   sum_sat;

    // Pipeline holds while a row end waits for the output buffer
    assign out_take = m_tvalid && m_tready;
    assign buf_free = !out_busy_reg
                      || (out_take && (out_cnt_reg == bbspmv_pkg::ROW_W'(bbspmv_pkg::BLOCK_EDGE-1)));
    assign advance  = !(s3_valid_reg && s3_eor_reg && !buf_free);
    assign s_tready = advance;
    assign out_load = advance && s3_valid_reg && s3_eor_reg;

    // ---------------- input register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (advance) begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s1_op_reg     <= bbspmv_pkg::op_t'(s_tuser);
            s1_index_reg  <= s_tdata[11:0];
            s1_data_reg   <= s_tdata[27:12];
            s1_bitmap_reg <= s_tdata[91:28];
            s1_column_reg <= s_tdata[100:92];
        end
    end

    // ---------------- issue stage: bitmap, column, fault, x access ----------------
    assign lo_bit    = bbspmv_pkg::lowest_set(pending_reg);
    assign have_bits = (pending_reg != '0);
    assign x_pos     = {column_reg, lo_bit[bbspmv_pkg::EDGE_LOG2-1:0]};
    assign x_ok      = ({1'b0, x_pos} < CMP_W'(MEM_DEPTH));
    assign wr_ok     = ({1'b0, s1_index_reg} < CMP_W'(MEM_DEPTH));

    always_comb begin
        pending_next  = pending_reg;
        column_next   = column_reg;
        fault_next    = fault_reg;
        s2_valid_next = 1'b0;
        mem_wr        = 1'b0;
        s2_next.eor   = 1'b0;
        s2_next.row   = lo_bit[bbspmv_pkg::BIT_IDX_W-1:bbspmv_pkg::EDGE_LOG2];
        s2_next.data  = s1_data_reg;
        s2_next.x_ok  = x_ok;
        s2_next.fault = fault_reg;
        if (s1_valid_reg) begin
            unique case (s1_op_reg)
                bbspmv_pkg::OP_LOAD_X: begin
                    mem_wr = wr_ok;
                end
                bbspmv_pkg::OP_HEADER: begin
                    if (have_bits) begin
                        fault_next = 1'b1;
                    end
                    pending_next = s1_bitmap_reg;
                    column_next  = s1_column_reg;
                end
                bbspmv_pkg::OP_VALUE: begin
                    if (have_bits) begin
                        pending_next  = pending_reg & (pending_reg - 1'b1);
                        s2_valid_next = 1'b1;
                    end else begin
                        fault_next = 1'b1;
                    end
                end
                bbspmv_pkg::OP_ROW_END: begin
                    s2_valid_next = 1'b1;
                    s2_next.eor   = 1'b1;
                    fault_next    = 1'b0;
                end
                default: begin
                    mem_wr = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg  <= '0;
            column_reg   <= '0;
            fault_reg    <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else if (advance) begin
            pending_reg  <= pending_next;
            column_reg   <= column_next;
            fault_reg    <= fault_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s2_reg <= s2_next;
        end
    end

    // x store: one write port for loads, one registered read port for values
    always_ff @(posedge aclk) begin
        if (advance && mem_wr) begin
            x_mem[s1_index_reg[ADDR_W-1:0]] <= s1_data_reg;
        end
        if (advance) begin
            x_rd_reg <= x_mem[x_pos[ADDR_W-1:0]];
        end
    end

    // ---------------- multiply stage ----------------
    assign x_operand = s2_reg.x_ok ? x_rd_reg : '0;
    assign prod_next = s2_reg.data * x_operand;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
        end else if (advance) begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s3_eor_reg   <= s2_reg.eor;
            s3_row_reg   <= s2_reg.row;
            s3_prod_reg  <= prod_next;
            s3_fault_reg <= s2_reg.fault;
        end
    end

    // ---------------- saturating accumulate stage ----------------
    assign sum_wide = {acc_reg[s3_row_reg][bbspmv_pkg::SUM_W-1], acc_reg[s3_row_reg]}
                      + (bbspmv_pkg::SUM_W+1)'(s3_prod_reg);

    always_comb begin
        if (sum_wide[bbspmv_pkg::SUM_W] != sum_wide[bbspmv_pkg::SUM_W-1]) begin
            sum_sat = sum_wide[bbspmv_pkg::SUM_W] ? bbspmv_pkg::ACC_MIN : bbspmv_pkg::ACC_MAX;
        end else begin
            sum_sat = sum_wide[bbspmv_pkg::SUM_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < bbspmv_pkg::BLOCK_EDGE; r++) begin
                acc_reg[r] <= '0;
            end
        end else if (advance && s3_valid_reg) begin
            if (s3_eor_reg) begin
                for (int r = 0; r < bbspmv_pkg::BLOCK_EDGE; r++) begin
                    acc_reg[r] <= '0;
                end
            end else begin
                acc_reg[s3_row_reg] <= sum_sat;
            end
        end
    end

    // ---------------- output buffer: eight sums shifted out ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_busy_reg <= 1'b0;
            out_cnt_reg  <= '0;
        end else if (out_load) begin
            out_busy_reg <= 1'b1;
            out_cnt_reg  <= '0;
        end else if (out_take) begin
            out_cnt_reg <= out_cnt_reg + 1'b1;
            if (out_cnt_reg == bbspmv_pkg::ROW_W'(bbspmv_pkg::BLOCK_EDGE-1)) begin
                out_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_fault_reg <= s3_fault_reg;
            for (int r = 0; r < bbspmv_pkg::BLOCK_EDGE; r++) begin
                out_sum_reg[r] <= acc_reg[r];
            end
        end else if (out_take) begin
            for (int r = 0; r < bbspmv_pkg::BLOCK_EDGE - 1; r++) begin
                out_sum_reg[r] <= out_sum_reg[r+1];
            end
        end
    end

    assign m_tvalid = out_busy_reg;
    assign m_tdata  = {5'b0, out_cnt_reg, out_sum_reg[0]};
    assign m_tlast  = (out_cnt_reg == bbspmv_pkg::ROW_W'(bbspmv_pkg::BLOCK_EDGE-1));
    assign m_tuser  = out_fault_reg;

`ifndef SYNTH
    // Input stalls only behind a busy output buffer
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> out_busy_reg)
        else $error("input stalled with idle output buffer");

    // A row end starts a fresh burst at local row 0
    a_burst_start: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> (out_busy_reg && out_cnt_reg == '0))
        else $error("row end did not start output burst");

    // Row end leaves row sums 0, 3 and 7 cleared
    a_acc_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> (acc_reg[0] == '0 && acc_reg[3] == '0 && acc_reg[7] == '0))
        else $error("row sums not cleared after row end");

    // Each consumed value retires exactly one pending bitmap bit
    a_bit_retire: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && s1_valid_reg && s1_op_reg == bbspmv_pkg::OP_VALUE && have_bits)
        |=> ($countones(pending_reg) + 1 == $countones($past(pending_reg))))
        else $error("value did not retire one pending bit");
`endif

endmodule
